/* hdl/itoa_pkg.sv */
// Package for the integer to ASCII radix converter.
// Holds the transaction structs, sequencer states, character codes and the digit glyph function.
// No dependencies; the top level and the checker refer to it by scoped names.
package itoa_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int IN_VALUE_W         = 32;
    localparam int RADIX_W            = 5;
    localparam int DIGIT_W            = 4;
    localparam int CHAR_W             = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_F     = 7'h46;

    typedef struct packed {
        logic                  func;
        logic [IN_VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_LOAD,
        ST_WAIT
    } t_state;

    // Maps a digit 0..15 onto '0'..'9' then 'A'..'F'.
    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] code;
        if (d < 4'd10) begin
            code = CHAR_ZERO + CHAR_W'(d);
        end else begin
            code = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
        end
        return code;
    endfunction

endpackage

/* hdl/itoa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the digit store of the converter.
module itoa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/integer_to_ascii_radix_top.sv */
// Top level of the integer to ASCII radix converter.
// Depends on itoa_pkg (types, states, glyph function) and itoa_ram (digit store).
//
// Usage
// -----
// The input channel (i_in_valid / o_in_ready / i_in_data) takes one word and a mode flag
// per transaction: func = 0 reads the word as unsigned, func = 1 as two's complement.
// The output channel (o_out_valid / i_out_ready / o_out_data) returns the number as ASCII,
// most significant digit first, with a leading '-' for a negative signed word; the final
// character carries last = 1. The radix (2..16, reset 10) is written through i_cfg_we and
// i_cfg_wdata; the user must write it only while the block is idle, which the block
// itself does not enforce. Out-of-range writes are clamped. The block handles one word
// at a time and drops o_in_ready from acceptance until the last character has been
// taken. Each digit comes from one pass of a shared restoring divider that retires one
// quotient bit per cycle. Each digit character then passes through a RAM read, an output
// load and the handshake, and a leading '-' through an output load and the handshake;
// the handshake waits as long as the receiver stalls. A stalled receiver simply holds
// the output register; nothing is lost. Synchronous reset clears the output valid flag,
// returns the sequencer to idle and sets the radix to 10.
module integer_to_ascii_radix_top #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  itoa_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output itoa_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [itoa_pkg::RADIX_W-1:0]     i_cfg_wdata
);

    localparam int ADDR_W = $clog2(VALUE_BITS);
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int BIT_W  = $clog2(VALUE_BITS);
    localparam int DW     = itoa_pkg::DIGIT_W;
    localparam int RW     = itoa_pkg::RADIX_W;

    itoa_pkg::t_state r_state, n_state;

    logic [RW-1:0]         r_radix;
    logic [VALUE_BITS-1:0] r_quot, n_quot;
    logic [DW-1:0]         r_rem, n_rem;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [ADDR_W-1:0]     r_idx, n_idx;
    logic                  r_neg, n_neg;
    logic                  r_out_valid, n_out_valid;
    itoa_pkg::t_out_item   r_out, n_out;

    // Input word brought to VALUE_BITS, whichever side of 32 that lies.
    logic [VALUE_BITS+itoa_pkg::IN_VALUE_W-1:0] in_ext;
    logic [VALUE_BITS-1:0]                      in_word;
    logic                                       in_neg;

    // One restoring division step.
    logic [RW-1:0] rem_shift;
    logic          step_ge;
    logic [RW-1:0] rem_diff;
    logic [DW-1:0] step_rem;
    logic [VALUE_BITS-1:0] step_quot;

    logic              ram_we;
    logic [DW-1:0]     ram_rdata;

    assign in_ext  = {{VALUE_BITS{1'b0}}, i_in_data.value};
    assign in_word = in_ext[VALUE_BITS-1:0];
    assign in_neg  = i_in_data.func & in_word[VALUE_BITS-1];

    assign rem_shift = {r_rem, r_quot[VALUE_BITS-1]};
    assign step_ge   = (rem_shift >= r_radix);
    assign rem_diff  = step_ge ? (rem_shift - r_radix) : rem_shift;
    assign step_rem  = rem_diff[DW-1:0];
    assign step_quot = {r_quot[VALUE_BITS-2:0], step_ge};

    assign ram_we = (r_state == itoa_pkg::ST_DIV) && (r_bit == BIT_W'(VALUE_BITS - 1));

    itoa_ram #(
        .WIDTH (DW),
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (step_rem),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Radix register with clamping to 2..16.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= itoa_pkg::RADIX_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_wdata < itoa_pkg::RADIX_MIN) begin
                r_radix <= itoa_pkg::RADIX_MIN;
            end else if (i_cfg_wdata > itoa_pkg::RADIX_MAX) begin
                r_radix <= itoa_pkg::RADIX_MAX;
            end else begin
                r_radix <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itoa_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_quot      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_quot      <= n_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_bit <= n_bit;
        r_idx <= n_idx;
        r_neg <= n_neg;
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_count     = r_count;
        n_idx       = r_idx;
        n_neg       = r_neg;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_in_ready  = 1'b0;

        case (r_state)
            itoa_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_quot  = in_neg ? (VALUE_BITS'(0) - in_word) : in_word;
                    n_neg   = in_neg;
                    n_rem   = '0;
                    n_bit   = '0;
                    n_count = '0;
                    n_state = itoa_pkg::ST_DIV;
                end
            end
            itoa_pkg::ST_DIV: begin
                n_quot = step_quot;
                n_rem  = step_rem;
                n_bit  = r_bit + BIT_W'(1);
                if (r_bit == BIT_W'(VALUE_BITS - 1)) begin
                    // Digit complete: it is written at r_count.
                    n_count = r_count + CNT_W'(1);
                    n_rem   = '0;
                    n_bit   = '0;
                    if ((step_quot == '0) || (n_count == CNT_W'(VALUE_BITS))) begin
                        n_idx   = r_count[ADDR_W-1:0];
                        n_state = r_neg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_READ;
                    end
                end
            end
            itoa_pkg::ST_SIGN: begin
                n_out_valid     = 1'b1;
                n_out.char_code = itoa_pkg::CHAR_MINUS;
                n_out.last      = 1'b0;
                n_state         = itoa_pkg::ST_WAIT;
            end
            itoa_pkg::ST_READ: begin
                n_state = itoa_pkg::ST_LOAD;
            end
            itoa_pkg::ST_LOAD: begin
                n_out_valid     = 1'b1;
                n_out.char_code = itoa_pkg::glyph(ram_rdata);
                n_out.last      = (r_idx == '0);
                n_idx           = r_idx - ADDR_W'(1);
                n_state         = itoa_pkg::ST_WAIT;
            end
            itoa_pkg::ST_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = r_out.last ? itoa_pkg::ST_IDLE : itoa_pkg::ST_READ;
                end
            end
            default: begin
                n_state     = itoa_pkg::ST_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hdl/itoa_checker.sv */
// Port-level checker for the integer to ASCII radix converter, bound to the top level.
// Depends on itoa_pkg for the transaction structs and character codes.
module itoa_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input itoa_pkg::t_out_item o_out_data
);

    // A waiting character keeps its value until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output transaction changed while stalled");

    // Only one word is in flight at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a word was in progress");

    a_no_ready_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while characters are pending");

    // After the final character the block is immediately free again.
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last) |=> o_in_ready)
        else $error("block not ready after the last character");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.char_code == itoa_pkg::CHAR_MINUS && !o_out_data.last)
            || (o_out_data.char_code >= itoa_pkg::CHAR_ZERO
                && o_out_data.char_code <= itoa_pkg::CHAR_NINE)
            || (o_out_data.char_code >= itoa_pkg::CHAR_A
                && o_out_data.char_code <= itoa_pkg::CHAR_F)))
        else $error("output character is neither a digit nor a leading minus");

endmodule

bind integer_to_ascii_radix_top itoa_checker u_itoa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
